// File: rtl/core/mclru_pkg.sv
// Shared constants, types and microcode word format for the mapping cache tag manager.
// Used by mclru_seq, mapping_cache_lru_lookup_top and mclru_props; no dependencies.
package mclru_pkg;

  localparam int BANKS       = 4;
  localparam int SLOTS       = 4;
  localparam int MAP_PAGES   = 256;
  localparam int ENTRIES     = 8;

  localparam int LPAGE_W     = 13;
  localparam int BANK_W      = $clog2(BANKS);
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int OFF_W       = $clog2(ENTRIES);
  localparam int MPAGE_W     = $clog2(MAP_PAGES);
  localparam int STAMP_W     = 32;
  localparam int ENTRY_W     = BANK_W + SLOT_W;
  localparam int NUM_ENTRIES = BANKS * SLOTS;
  localparam int FLASH_DEPTH = BANKS * MAP_PAGES;
  localparam int FLASH_AW    = $clog2(FLASH_DEPTH);

  // Microcode step addresses.
  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_SCAN   = 2'd2,
    ST_COMMIT = 2'd3
  } step_t;

  // Datapath operation selected by a control word.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_FETCH  = 2'd1,
    OP_SCAN   = 2'd2,
    OP_COMMIT = 2'd3
  } uop_t;

  // Condition that selects the jump target over the fall-through step.
  typedef enum logic [1:0] {
    C_CLR_DONE  = 2'd0,
    C_IN_VALID  = 2'd1,
    C_SCAN_LAST = 2'd2,
    C_OUT_FREE  = 2'd3
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    step_t  jump;
    step_t  next;
  } uword_t;

  // Status from the datapath that the sequencer tests.
  typedef struct packed {
    logic in_valid;
    logic clr_done;
    logic scan_last;
    logic out_free;
  } flags_t;

  // Sequencer outputs to the datapath.
  typedef struct packed {
    uop_t op;
    logic go;
  } ctl_t;

endpackage

// File: rtl/core/mapping_cache_lru_lookup_top.sv
// Top level of the mapping cache tag manager: slot tag/state arrays, scan datapath and
// result register. Depends on mclru_pkg, mclru_seq and mclru_ram.
//
// Each transaction looks up one logical page in its bank and returns one result. A
// transaction accepts the request and reads the on-flash bitmap, then steps through
// each slot of the bank (4) to compare tags, find the first empty slot and track the
// oldest use stamp, and ends with a commit step that updates the slot state and loads
// the result register. The commit step waits while an earlier result has not been
// taken. After reset the block clears its 1024-entry on-flash bitmap, one entry per
// cycle, and accepts no request until that clear is done.
module mapping_cache_lru_lookup_top import mclru_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [LPAGE_W-1:0] in_logical_page,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BANK_W-1:0]  out_bank,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [OFF_W-1:0]   out_entry_offset,
  output logic               out_hit,
  output logic               out_unmapped,
  output logic               out_flush,
  output logic [MPAGE_W-1:0] out_flush_map_page,
  output logic               out_fill
);

  flags_t flags;
  ctl_t   ctl;

  // Request registers.
  logic               mode_r;
  logic [BANK_W-1:0]  bank_r;
  logic [MPAGE_W-1:0] mp_r;
  logic [OFF_W-1:0]   off_r;

  // Scan registers.
  logic [SLOT_W-1:0]  idx_r;
  logic               found_r;
  logic [SLOT_W-1:0]  hit_slot_r;
  logic               empty_r;
  logic [SLOT_W-1:0]  empty_slot_r;
  logic [STAMP_W-1:0] best_r;
  logic [SLOT_W-1:0]  lru_slot_r;

  // Per-slot state.
  logic [MPAGE_W-1:0] tag_r   [NUM_ENTRIES];
  logic [STAMP_W-1:0] stamp_r [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_r;
  logic [NUM_ENTRIES-1:0] dirty_r;
  logic [STAMP_W-1:0] use_cnt_r;

  logic [FLASH_AW-1:0] clr_cnt_r;

  // Result register.
  logic               out_valid_r;
  logic [BANK_W-1:0]  out_bank_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [OFF_W-1:0]   out_off_r;
  logic               out_hit_r;
  logic               out_unmapped_r;
  logic               out_flush_r;
  logic [MPAGE_W-1:0] out_fpage_r;
  logic               out_fill_r;

  logic               accept;
  logic               commit;
  logic [ENTRY_W-1:0] scan_ent;
  logic [SLOT_W-1:0]  victim;
  logic [ENTRY_W-1:0] vict_ent;
  logic [ENTRY_W-1:0] hit_ent;
  logic [MPAGE_W-1:0] vict_tag;
  logic               do_flush;
  logic               on_flash;
  logic               unmapped;

  logic               ram_we;
  logic [FLASH_AW-1:0] ram_waddr;
  logic               ram_wdata;
  logic [FLASH_AW-1:0] ram_raddr;
  logic               ram_rdata_w;

  assign in_ready = (ctl.op == OP_FETCH);
  assign accept   = in_valid && in_ready;
  assign commit   = (ctl.op == OP_COMMIT) && ctl.go;

  assign flags.in_valid  = in_valid;
  assign flags.clr_done  = (clr_cnt_r == FLASH_AW'(FLASH_DEPTH - 1));
  assign flags.scan_last = (idx_r == SLOT_W'(SLOTS - 1));
  assign flags.out_free  = !out_valid_r || out_ready;

  mclru_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  always_comb begin
    scan_ent = {bank_r, idx_r};
    victim   = empty_r ? empty_slot_r : lru_slot_r;
    vict_ent = {bank_r, victim};
    hit_ent  = {bank_r, hit_slot_r};
    vict_tag = tag_r[vict_ent];
    on_flash = ram_rdata_w;
    do_flush = !found_r && !empty_r && dirty_r[vict_ent] && (mode_r || on_flash);
    unmapped = !found_r && !mode_r && !on_flash;
  end

  // The bitmap read address follows the incoming request while idle, so the read data
  // is ready by the end of the scan and holds while the request is in flight.
  assign ram_raddr = in_ready
                   ? {in_logical_page[BANK_W-1:0],
                      in_logical_page[BANK_W+OFF_W +: MPAGE_W]}
                   : {bank_r, mp_r};

  always_comb begin
    if (ctl.op == OP_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = commit && do_flush;
      ram_waddr = {bank_r, vict_tag};
      ram_wdata = 1'b1;
    end
  end

  mclru_ram #(
    .WIDTH (1),
    .DEPTH (FLASH_DEPTH)
  ) u_flash_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_w)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      dirty_r     <= '0;
      use_cnt_r   <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      empty_r     <= 1'b0;
    end else begin
      if (ctl.op == OP_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        empty_r <= 1'b0;
      end
      if (ctl.op == OP_SCAN) begin
        idx_r <= idx_r + 1'b1;
        if (!found_r && valid_r[scan_ent] && tag_r[scan_ent] == mp_r) begin
          found_r <= 1'b1;
        end
        if (!empty_r && !valid_r[scan_ent]) begin
          empty_r <= 1'b1;
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        if (found_r) begin
          use_cnt_r <= use_cnt_r + 1'b1;
          if (mode_r) begin
            dirty_r[hit_ent] <= 1'b1;
          end
        end else if (!unmapped) begin
          use_cnt_r         <= use_cnt_r + 1'b1;
          valid_r[vict_ent] <= 1'b1;
          dirty_r[vict_ent] <= mode_r;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      bank_r <= in_logical_page[BANK_W-1:0];
      off_r  <= in_logical_page[BANK_W +: OFF_W];
      mp_r   <= in_logical_page[BANK_W+OFF_W +: MPAGE_W];
    end
    if (ctl.op == OP_SCAN) begin
      if (!found_r && valid_r[scan_ent] && tag_r[scan_ent] == mp_r) begin
        hit_slot_r <= idx_r;
      end
      if (!empty_r && !valid_r[scan_ent]) begin
        empty_slot_r <= idx_r;
      end
      // Oldest stamp, lowest slot on ties; only consulted when every slot is valid.
      if (idx_r == '0 || stamp_r[scan_ent] < best_r) begin
        best_r     <= stamp_r[scan_ent];
        lru_slot_r <= idx_r;
      end
    end
    if (commit) begin
      out_bank_r     <= bank_r;
      out_off_r      <= off_r;
      out_hit_r      <= found_r;
      out_unmapped_r <= unmapped;
      out_flush_r    <= do_flush;
      out_fpage_r    <= do_flush ? vict_tag : '0;
      out_fill_r     <= !found_r && on_flash;
      if (found_r) begin
        out_slot_r        <= hit_slot_r;
        stamp_r[hit_ent]  <= use_cnt_r;
      end else if (unmapped) begin
        out_slot_r <= '0;
      end else begin
        out_slot_r        <= victim;
        tag_r[vict_ent]   <= mp_r;
        stamp_r[vict_ent] <= use_cnt_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bank           = out_bank_r;
  assign out_slot           = out_slot_r;
  assign out_entry_offset   = out_off_r;
  assign out_hit            = out_hit_r;
  assign out_unmapped       = out_unmapped_r;
  assign out_flush          = out_flush_r;
  assign out_flush_map_page = out_fpage_r;
  assign out_fill           = out_fill_r;

endmodule

// File: rtl/core/mclru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mclru_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mclru_seq.sv
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on mclru_pkg.
module mclru_seq import mclru_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctl_t   ctl
);

  step_t  pc_r, pc_nxt;
  uword_t uw;
  logic   cond_met;

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    unique case (s)
      ST_CLEAR:  w = '{op: OP_CLEAR,  cond: C_CLR_DONE,  jump: ST_IDLE,   next: ST_CLEAR};
      ST_IDLE:   w = '{op: OP_FETCH,  cond: C_IN_VALID,  jump: ST_SCAN,   next: ST_IDLE};
      ST_SCAN:   w = '{op: OP_SCAN,   cond: C_SCAN_LAST, jump: ST_COMMIT, next: ST_SCAN};
      ST_COMMIT: w = '{op: OP_COMMIT, cond: C_OUT_FREE,  jump: ST_IDLE,   next: ST_COMMIT};
    endcase
    return w;
  endfunction

  always_comb begin
    uw = ucode_rom(pc_r);
    unique case (uw.cond)
      C_CLR_DONE:  cond_met = flags.clr_done;
      C_IN_VALID:  cond_met = flags.in_valid;
      C_SCAN_LAST: cond_met = flags.scan_last;
      C_OUT_FREE:  cond_met = flags.out_free;
    endcase
    pc_nxt = cond_met ? uw.jump : uw.next;
    ctl.op = uw.op;
    ctl.go = cond_met;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_CLEAR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: rtl/core/mclru_checker.sv
// Port-level assertions for the mapping cache tag manager, bound to the top level.
// Depends on mclru_pkg and mapping_cache_lru_lookup_top.
module mclru_props import mclru_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BANK_W-1:0]  out_bank,
  input logic [SLOT_W-1:0]  out_slot,
  input logic               out_hit,
  input logic               out_unmapped,
  input logic               out_flush,
  input logic [MPAGE_W-1:0] out_flush_map_page,
  input logic               out_fill
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_bank)
      && $stable(out_flush_map_page))
    else $error("result changed while stalled");

  // An accepted request keeps the block busy for the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted during scan");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_unmapped && !out_flush && !out_fill)
    else $error("hit with miss side effects");

  a_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unmapped |-> out_slot == '0 && !out_hit && !out_flush && !out_fill)
    else $error("unmapped read with side effects");

  a_no_flush_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flush |-> out_flush_map_page == '0)
    else $error("write-back page reported without write-back");

endmodule

bind mapping_cache_lru_lookup_top mclru_props u_mclru_props (.*);
